// File: sv/bounded_ordered_list_engine_defines.svh
// Assertion macros shared by the checker of the ordered list engine.
// Needs nothing else; each macro names its clock and active-low reset.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BOLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BOLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bole_pkg.sv
// Shared types and constants of the ordered list engine.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package bole_pkg;

  localparam int OP_W    = 4;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 5;
  localparam int ST_W    = 3;
  localparam int LIM_W   = 5;
  localparam int CNTO_W  = 5;

  localparam logic [LIM_W-1:0] LIM_RESET = 5'd16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INS_FRONT = 4'd0;
  localparam logic [OP_W-1:0] OP_INS_END   = 4'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 4'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 4'd3;
  localparam logic [OP_W-1:0] OP_DEL_END   = 4'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 4'd5;
  localparam logic [OP_W-1:0] OP_DEL_VALUE = 4'd6;
  localparam logic [OP_W-1:0] OP_REVERSE   = 4'd7;
  localparam logic [OP_W-1:0] OP_DUMP      = 4'd8;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  // Datapath actions, one per cycle.
  typedef enum logic [4:0] {
    ACT_NONE      = 5'd0,
    ACT_LOAD      = 5'd1,
    ACT_SET_INS   = 5'd2,
    ACT_SET_DEL   = 5'd3,
    ACT_SET_SCAN  = 5'd4,
    ACT_SET_REV   = 5'd5,
    ACT_SET_DUMP  = 5'd6,
    ACT_SHIFT     = 5'd7,
    ACT_SCAN      = 5'd8,
    ACT_INS_FIN   = 5'd9,
    ACT_DEL_FIN   = 5'd10,
    ACT_REV_RI    = 5'd11,
    ACT_REV_RJ    = 5'd12,
    ACT_REV_WI    = 5'd13,
    ACT_REV_WJ    = 5'd14,
    ACT_DUMP_RD   = 5'd15,
    ACT_DUMP_EMIT = 5'd16,
    ACT_RESULT    = 5'd17
  } act_e;

  // Which index an insert or delete works at.
  typedef enum logic [1:0] {
    K_ZERO = 2'd0,
    K_CNT  = 2'd1,
    K_POS  = 2'd2,
    K_LAST = 2'd3
  } ksel_e;

  typedef struct packed {
    act_e             act;
    ksel_e            ksel;
    logic [ST_W-1:0]  st;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic pos_ok;
    logic rem_zero;
    logic rem_one;
    logic hit;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: sv/bole_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/bole_ctrl.sv
// Controller state machine of the ordered list engine.
// Depends on bole_pkg; drives the datapath through cmd_t and reads stat_t.
`timescale 1ns / 1ps
`default_nettype none

module bole_ctrl import bole_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [OP_W-1:0] in_op_i,
  output      logic            in_ready_o,
  output      cmd_t            cmd_o,
  input  wire stat_t           stat_i
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DECODE   = 12'b0000_0000_0010,
    S_SHIFT    = 12'b0000_0000_0100,
    S_FIN      = 12'b0000_0000_1000,
    S_SCAN     = 12'b0000_0001_0000,
    S_REV_I    = 12'b0000_0010_0000,
    S_REV_J    = 12'b0000_0100_0000,
    S_REV_WI   = 12'b0000_1000_0000,
    S_REV_WJ   = 12'b0001_0000_0000,
    S_DUMP_RD  = 12'b0010_0000_0000,
    S_DUMP_OUT = 12'b0100_0000_0000,
    S_RESULT   = 12'b1000_0000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [OP_W-1:0] op_q, op_d;
  logic [ST_W-1:0] st_q, st_d;
  logic            ins_q, ins_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_INS_FRONT;
      st_q    <= ST_OK;
      ins_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      st_q    <= st_d;
      ins_q   <= ins_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    st_d        = st_q;
    ins_d       = ins_q;
    cmd_o.act   = ACT_NONE;
    cmd_o.ksel  = K_ZERO;
    cmd_o.st    = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.act = ACT_LOAD;
          op_d      = in_op_i;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        st_d    = ST_OK;
        state_d = S_RESULT;
        unique case (op_q)
          OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
            ins_d = 1'b1;
            if (op_q == OP_INS_AT && !stat_i.pos_ok) begin
              st_d = ST_BADPOS;
            end else if (stat_i.full) begin
              st_d = ST_FULL;
            end else begin
              cmd_o.act  = ACT_SET_INS;
              cmd_o.ksel = (op_q == OP_INS_FRONT) ? K_ZERO :
                           (op_q == OP_INS_END)   ? K_CNT  : K_POS;
              state_d    = S_SHIFT;
            end
          end
          OP_DEL_FRONT, OP_DEL_END: begin
            ins_d = 1'b0;
            if (stat_i.empty) begin
              st_d = ST_EMPTY;
            end else begin
              cmd_o.act  = ACT_SET_DEL;
              cmd_o.ksel = (op_q == OP_DEL_FRONT) ? K_ZERO : K_LAST;
              state_d    = S_SHIFT;
            end
          end
          OP_DEL_AT: begin
            ins_d = 1'b0;
            if (!stat_i.pos_ok) begin
              st_d = ST_BADPOS;
            end else begin
              cmd_o.act  = ACT_SET_DEL;
              cmd_o.ksel = K_POS;
              state_d    = S_SHIFT;
            end
          end
          OP_DEL_VALUE: begin
            ins_d = 1'b0;
            if (stat_i.empty) begin
              st_d = ST_EMPTY;
            end else begin
              cmd_o.act = ACT_SET_SCAN;
              state_d   = S_SCAN;
            end
          end
          OP_REVERSE: begin
            cmd_o.act = ACT_SET_REV;
            state_d   = S_REV_I;
          end
          OP_DUMP: begin
            if (stat_i.empty) begin
              st_d = ST_EMPTY;
            end else begin
              cmd_o.act = ACT_SET_DUMP;
              state_d   = S_DUMP_RD;
            end
          end
          default: begin
            // Undefined operations just report ok.
            state_d = S_RESULT;
          end
        endcase
      end
      S_SHIFT: begin
        cmd_o.act = ACT_SHIFT;
        if (stat_i.rem_zero) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.act = ins_q ? ACT_INS_FIN : ACT_DEL_FIN;
        state_d   = S_RESULT;
      end
      S_SCAN: begin
        cmd_o.act = ACT_SCAN;
        if (stat_i.hit) begin
          state_d = S_SHIFT;
        end else if (stat_i.rem_zero) begin
          st_d    = ST_NOTFOUND;
          state_d = S_RESULT;
        end
      end
      S_REV_I: begin
        cmd_o.act = ACT_REV_RI;
        state_d   = stat_i.rem_zero ? S_RESULT : S_REV_J;
      end
      S_REV_J: begin
        cmd_o.act = ACT_REV_RJ;
        state_d   = S_REV_WI;
      end
      S_REV_WI: begin
        cmd_o.act = ACT_REV_WI;
        state_d   = S_REV_WJ;
      end
      S_REV_WJ: begin
        cmd_o.act = ACT_REV_WJ;
        state_d   = stat_i.rem_one ? S_RESULT : S_REV_J;
      end
      S_DUMP_RD: begin
        cmd_o.act = ACT_DUMP_RD;
        state_d   = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        cmd_o.act = ACT_DUMP_EMIT;
        if (stat_i.out_free) begin
          state_d = stat_i.rem_one ? S_IDLE : S_DUMP_RD;
        end
      end
      S_RESULT: begin
        cmd_o.act = ACT_RESULT;
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/bole_dp.sv
// Datapath of the ordered list engine: element RAM, walk pointers, count,
// limit register and the result register. Depends on bole_pkg and bole_ram.
`timescale 1ns / 1ps
`default_nettype none

module bole_dp import bole_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [LIM_W-1:0]  cfg_wdata_i,
  input  wire logic [VAL_W-1:0]  in_value_i,
  input  wire logic [POS_W-1:0]  in_position_i,
  input  wire cmd_t              cmd_i,
  output      stat_t             stat_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      logic [ST_W-1:0]   out_status_o,
  output      logic [VAL_W-1:0]  out_element_o,
  output      logic              out_last_o,
  output      logic [CNTO_W-1:0] out_count_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int MW = (CW > POS_W) ? CW : POS_W;

  logic [VAL_W-1:0] val_q, val_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [LIM_W-1:0] lim_q;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    aux_q, aux_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [IW-1:0]    pdst_q, pdst_d;
  logic             pend_q, pend_d;
  logic             dir_q, dir_d;   // high: left shift (delete)
  logic [VAL_W-1:0] tmp_q, tmp_d;

  logic              outv_q, outv_d;
  logic [ST_W-1:0]   ost_q, ost_d;
  logic [VAL_W-1:0]  oel_q, oel_d;
  logic              olast_q, olast_d;
  logic [CNTO_W-1:0] ocnt_q, ocnt_d;

  logic             ram_we, ram_re;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  logic [MW-1:0] cnt_ext, pos_ext, lim_ext, cap_ext;
  logic [CW-1:0] k;
  logic [CW-1:0] ptr_inc;
  logic          out_free, hit;

  bole_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cnt_ext  = MW'(cnt_q);
  assign pos_ext  = MW'(pos_q);
  assign lim_ext  = MW'(lim_q);
  assign cap_ext  = MW'(CAPACITY);
  assign out_free = !outv_q || out_ready_i;
  assign hit      = pend_q && (ram_rdata == val_q);
  assign ptr_inc  = ptr_q + CW'(1);

  always_comb begin
    unique case (cmd_i.ksel)
      K_ZERO:  k = '0;
      K_CNT:   k = cnt_q;
      K_POS:   k = CW'(pos_ext - MW'(1));
      K_LAST:  k = cnt_q - CW'(1);
      default: k = '0;
    endcase
  end

  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.full     = (cnt_ext >= lim_ext) || (cnt_ext >= cap_ext);
  assign stat_o.pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign stat_o.rem_zero = (rem_q == '0);
  assign stat_o.rem_one  = (rem_q == CW'(1));
  assign stat_o.hit      = hit;
  assign stat_o.out_free = out_free;

  always_comb begin
    val_d     = val_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    aux_d     = aux_q;
    rem_d     = rem_q;
    pdst_d    = pdst_q;
    pend_d    = pend_q;
    dir_d     = dir_q;
    tmp_d     = tmp_q;
    ost_d     = ost_q;
    oel_d     = oel_q;
    olast_d   = olast_q;
    ocnt_d    = ocnt_q;
    outv_d    = out_ready_i ? 1'b0 : outv_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = pdst_q;
    ram_wdata = ram_rdata;
    ram_raddr = ptr_q[IW-1:0];
    unique case (cmd_i.act)
      ACT_NONE: begin
      end
      ACT_LOAD: begin
        val_d = in_value_i;
        pos_d = in_position_i;
      end
      ACT_SET_INS: begin
        // Move entries cnt-1 down to k one place right, then write at k.
        aux_d  = k;
        ptr_d  = cnt_q - CW'(1);
        rem_d  = cnt_q - k;
        dir_d  = 1'b0;
        pend_d = 1'b0;
      end
      ACT_SET_DEL: begin
        ptr_d  = k + CW'(1);
        rem_d  = cnt_q - CW'(1) - k;
        dir_d  = 1'b1;
        pend_d = 1'b0;
      end
      ACT_SET_SCAN, ACT_SET_DUMP: begin
        ptr_d  = '0;
        rem_d  = cnt_q;
        pend_d = 1'b0;
      end
      ACT_SET_REV: begin
        ptr_d = '0;
        aux_d = cnt_q - CW'(1);
        rem_d = cnt_q >> 1;
      end
      ACT_SHIFT: begin
        // Read one entry per cycle; the entry read last cycle is written
        // to its new place in this one.
        ram_we = pend_q;
        if (rem_q != '0) begin
          ram_re = 1'b1;
          pdst_d = dir_q ? (ptr_q[IW-1:0] - IW'(1)) : (ptr_q[IW-1:0] + IW'(1));
          ptr_d  = dir_q ? ptr_inc : (ptr_q - CW'(1));
          rem_d  = rem_q - CW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      ACT_SCAN: begin
        if (hit) begin
          // Match found: set up the left shift that removes it.
          ptr_d  = CW'(pdst_q) + CW'(1);
          rem_d  = cnt_q - CW'(1) - CW'(pdst_q);
          dir_d  = 1'b1;
          pend_d = 1'b0;
        end else if (rem_q != '0) begin
          ram_re = 1'b1;
          pdst_d = ptr_q[IW-1:0];
          ptr_d  = ptr_inc;
          rem_d  = rem_q - CW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      ACT_INS_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = aux_q[IW-1:0];
        ram_wdata = val_q;
        cnt_d     = cnt_q + CW'(1);
      end
      ACT_DEL_FIN: begin
        cnt_d = cnt_q - CW'(1);
      end
      ACT_REV_RI, ACT_DUMP_RD: begin
        ram_re = 1'b1;
      end
      ACT_REV_RJ: begin
        tmp_d     = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = aux_q[IW-1:0];
      end
      ACT_REV_WI: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[IW-1:0];
      end
      ACT_REV_WJ: begin
        ram_we    = 1'b1;
        ram_waddr = aux_q[IW-1:0];
        ram_wdata = tmp_q;
        ptr_d     = ptr_inc;
        aux_d     = aux_q - CW'(1);
        rem_d     = rem_q - CW'(1);
        // Start reading the next low-side entry while this pair finishes.
        ram_re    = (rem_q != CW'(1));
        ram_raddr = ptr_inc[IW-1:0];
      end
      ACT_DUMP_EMIT: begin
        if (out_free) begin
          outv_d  = 1'b1;
          ost_d   = ST_OK;
          oel_d   = ram_rdata;
          olast_d = (rem_q == CW'(1));
          ocnt_d  = cnt_ext[CNTO_W-1:0];
          ptr_d   = ptr_inc;
          rem_d   = rem_q - CW'(1);
        end
      end
      ACT_RESULT: begin
        if (out_free) begin
          outv_d  = 1'b1;
          ost_d   = cmd_i.st;
          oel_d   = '0;
          olast_d = 1'b1;
          ocnt_d  = cnt_ext[CNTO_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      lim_q  <= LIM_RESET;
      rem_q  <= '0;
      pend_q <= 1'b0;
      dir_q  <= 1'b0;
      outv_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
      rem_q  <= rem_d;
      pend_q <= pend_d;
      dir_q  <= dir_d;
      outv_q <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    pos_q   <= pos_d;
    ptr_q   <= ptr_d;
    aux_q   <= aux_d;
    pdst_q  <= pdst_d;
    tmp_q   <= tmp_d;
    ost_q   <= ost_d;
    oel_q   <= oel_d;
    olast_q <= olast_d;
    ocnt_q  <= ocnt_d;
  end

  assign out_valid_o   = outv_q;
  assign out_status_o  = ost_q;
  assign out_element_o = oel_q;
  assign out_last_o    = olast_q;
  assign out_count_o   = ocnt_q;

endmodule

`default_nettype wire

// File: sv/bounded_ordered_list_engine.sv
// Channel   Dir  Handshake                          Payload
// config    in   cfg_we_i                           cfg_wdata_i: max_entries
// request   in   s_axis_tvalid_i / s_axis_tready_o  s_axis_tdata_i: op, value, position
// result    out  m_axis_tvalid_o / m_axis_tready_i  m_axis_tdata_o, m_axis_tlast_o
//
// One request at a time; it is decoded, then walks over the element RAM (one
// read and one write per cycle): inserts move entries from index k on one
// place right, deletes those after k one place left (k zero-based), delete by
// value scans then shifts, reverse swaps pairs, dump reads each element; refused
// ones go straight to the result. Reset clears the count and restores the
// limit to 16. A stalled result register holds a dump walk until it is taken.
// Ordered list top level; depends on bole_pkg, bole_ctrl and bole_dp.
`timescale 1ns / 1ps
`default_nettype none

module bounded_ordered_list_engine import bole_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LIM_W-1:0] cfg_wdata_i,     // max_entries
  input  wire logic             s_axis_tvalid_i,
  output      logic             s_axis_tready_o,
  input  wire logic [47:0]      s_axis_tdata_i,  // op[3:0], value[35:4], position[40:36]
  output      logic             m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output      logic [39:0]      m_axis_tdata_o,  // status[2:0], element[34:3], count[39:35]
  output      logic             m_axis_tlast_o
);

  cmd_t              cmd;
  stat_t             stat;
  logic [ST_W-1:0]   out_status;
  logic [VAL_W-1:0]  out_element;
  logic [CNTO_W-1:0] out_count;

  bole_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tdata_i[3:0]),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  bole_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_value_i    (s_axis_tdata_i[35:4]),
    .in_position_i (s_axis_tdata_i[40:36]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_status_o  (out_status),
    .out_element_o (out_element),
    .out_last_o    (m_axis_tlast_o),
    .out_count_o   (out_count)
  );

  assign m_axis_tdata_o = {out_count, out_element, out_status};

endmodule

`default_nettype wire

// File: sv/bole_checker.sv
// Port-level checks of the ordered list engine, bound to the top level.
// Depends on bole_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_ordered_list_engine_defines.svh"

module bole_checker import bole_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);

  // Only one request is worked on at a time.
  `BOLE_ASSERT_NXT(a_one_request, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "request taken while another is in work")

  `BOLE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "stalled result changed")

  // Only a dump gives several results, and all of those are ok.
  `BOLE_ASSERT_IMP(a_mid_ok, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tlast_o, m_axis_tdata_o[2:0] == ST_OK, "non-final result with bad status")

  `BOLE_ASSERT_IMP(a_refused_zero, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tdata_o[2:0] != ST_OK), (m_axis_tdata_o[34:3] == 32'd0) && m_axis_tlast_o, "refused request gave element or several results")

  `BOLE_ASSERT_IMP(a_count_cap, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[39:35] <= CAPACITY, "count above capacity")

endmodule

bind bounded_ordered_list_engine bole_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

`default_nettype wire

// File: tb/sv/tb_bounded_ordered_list_engine.sv
// Self-checking testbench for the bounded ordered list engine.
// A list tracker class predicts every result from the accepted requests; depends on bole_pkg
// and the bounded_ordered_list_engine top level.
`timescale 1ns / 1ps

module tb_bounded_ordered_list_engine;
  import bole_pkg::*;

  localparam int LIST_CAP       = 16;
  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PER_SET = 53;

  // Codes 9..15 carry no operation; the block answers them with a plain ok.
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 4'd9;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 4'd15;

  typedef struct {
    logic [ST_W-1:0]   status;
    logic [VAL_W-1:0]  element;
    logic              last;
    logic [CNTO_W-1:0] count;
  } list_result_t;

  class list_tracker;
    logic [VAL_W-1:0] elems [LIST_CAP];
    int unsigned      count;
    int unsigned      limit;
    list_result_t     expected_q [$];
    int unsigned      errors;

    function new();
      count  = 0;
      limit  = LIM_RESET;
      errors = 0;
    endfunction

    function void push_result(logic [ST_W-1:0] st, logic [VAL_W-1:0] el, logic last);
      list_result_t r;
      r.status  = st;
      r.element = el;
      r.last    = last;
      r.count   = count[CNTO_W-1:0];
      expected_q.push_back(r);
    endfunction

    function logic [ST_W-1:0] insert_at(int unsigned idx, logic [VAL_W-1:0] v);
      int unsigned lim;
      lim = (limit > LIST_CAP) ? LIST_CAP : limit;
      if (count >= lim) return ST_FULL;
      for (int unsigned i = count; i > idx; i--) elems[i] = elems[i-1];
      elems[idx] = v;
      count++;
      return ST_OK;
    endfunction

    function void remove_at(int unsigned idx);
      for (int unsigned i = idx; i + 1 < count; i++) elems[i] = elems[i+1];
      count--;
    endfunction

    // Applies one accepted request to the tracked list and queues its results.
    function void note_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] value,
                               logic [POS_W-1:0] pos);
      logic [ST_W-1:0]  st;
      logic [VAL_W-1:0] tmp;
      int unsigned      hit;
      st = ST_OK;
      case (op)
        OP_INS_FRONT: st = insert_at(0, value);
        OP_INS_END:   st = insert_at(count, value);
        OP_INS_AT: begin
          if (pos < 1 || pos > count) st = ST_BADPOS;
          else st = insert_at(pos - 1, value);
        end
        OP_DEL_FRONT: begin
          if (count == 0) st = ST_EMPTY;
          else remove_at(0);
        end
        OP_DEL_END: begin
          if (count == 0) st = ST_EMPTY;
          else count--;
        end
        OP_DEL_AT: begin
          if (pos < 1 || pos > count) st = ST_BADPOS;
          else remove_at(pos - 1);
        end
        OP_DEL_VALUE: begin
          if (count == 0) begin
            st = ST_EMPTY;
          end else begin
            hit = 0;
            while (hit < count && elems[hit] != value) hit++;
            if (hit >= count) st = ST_NOTFOUND;
            else remove_at(hit);
          end
        end
        OP_REVERSE: begin
          for (int unsigned i = 0; i < count / 2; i++) begin
            tmp                 = elems[i];
            elems[i]            = elems[count-1-i];
            elems[count-1-i]    = tmp;
          end
        end
        OP_DUMP: begin
          if (count == 0) begin
            push_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < count; i++)
              push_result(ST_OK, elems[i], (i + 1 == count));
          end
          return;
        end
        default: ;
      endcase
      push_result(st, '0, 1'b1);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none pending: status %0d element %0h last %0b count %0d",
                 $time, got.status, got.element, got.last, got.count);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
      end
      if (got.element !== want.element) begin
        errors++;
        $display("%0t: element expected %0h got %0h", $time, want.element, got.element);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
      end
      if (got.count !== want.count) begin
        errors++;
        $display("%0t: count expected %0d got %0d", $time, want.count, got.count);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic [LIM_W-1:0]  cfg_wdata_i     = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [47:0]       s_axis_tdata_i  = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b1;
  logic [39:0]       m_axis_tdata_o;
  logic              m_axis_tlast_o;

  list_tracker board;
  int unsigned idle_cycles;
  int unsigned rx_cycle;
  int unsigned rx_mode;

  bounded_ordered_list_engine #(.CAPACITY(LIST_CAP)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: sample at the edge, so only pre-edge values are seen.
  always @(posedge clk_i) begin
    list_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.status  = m_axis_tdata_o[2:0];
      got.element = m_axis_tdata_o[34:3];
      got.last    = m_axis_tlast_o;
      got.count   = m_axis_tdata_o[39:35];
      board.check_result(got);
    end
  end

  // The receiver switches between always ready, random stalls and a fixed
  // pattern that is ready only when rx_cycle modulo 4 equals 3.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 100 == 0) rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= ($urandom_range(0, 2) != 0);
        default: m_axis_tready_i <= (rx_cycle % 4 == 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Leaves valid high on return so that back-to-back requests need no toggle.
  task automatic send_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] value,
                              logic [POS_W-1:0] pos);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, pos, value, op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_request(op, value, pos);
  endtask

  task automatic pause_sender(int unsigned cycles);
    if (cycles > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Waits until every pending result is in and the block has gone quiet.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] lim);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.limit = lim;
  endtask

  task automatic send_random();
    int unsigned      r;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 14)      op = OP_INS_FRONT;
    else if (r < 30) op = OP_INS_END;
    else if (r < 42) op = OP_INS_AT;
    else if (r < 50) op = OP_DEL_FRONT;
    else if (r < 58) op = OP_DEL_END;
    else if (r < 68) op = OP_DEL_AT;
    else if (r < 80) op = OP_DEL_VALUE;
    else if (r < 86) op = OP_REVERSE;
    else if (r < 94) op = OP_DUMP;
    else             op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    // Small values repeat often, which gives duplicates for delete by value.
    if ($urandom_range(0, 2) == 0) value = $urandom_range(0, 7);
    else value = $urandom();
    if (op == OP_DEL_VALUE && board.count > 0 && $urandom_range(0, 2) != 0)
      value = board.elems[$urandom_range(0, board.count - 1)];
    if ($urandom_range(0, 3) != 0) pos = POS_W'($urandom_range(0, board.count + 1));
    else pos = POS_W'($urandom_range(0, 31));
    send_request(op, value, pos);
  endtask

  task automatic run_random(int unsigned n);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < n) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      while (burst > 0 && sent < n) begin
        send_random();
        sent++;
        burst--;
      end
      if ($urandom_range(0, 29) == 0) drain_results();
      else pause_sender($urandom_range(0, 6));
    end
  endtask

  initial begin
    logic [LIM_W-1:0] limits [7];
    limits = '{5'd2, 5'd0, 5'd31, 5'd1, 5'd16, 5'd7, 5'd20};
    board = new();
    idle_cycles = 0;
    rx_cycle    = 0;
    rx_mode     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list, refused operations, then a few elements at the value extremes.
    send_request(OP_DUMP,      32'd0,        5'd0);
    send_request(OP_DEL_FRONT, 32'd0,        5'd0);
    send_request(OP_DEL_END,   32'd0,        5'd0);
    send_request(OP_DEL_VALUE, 32'd0,        5'd0);
    send_request(OP_DEL_AT,    32'd0,        5'd1);
    send_request(OP_INS_AT,    32'd9,        5'd1);
    send_request(OP_REVERSE,   32'd0,        5'd0);
    send_request(OP_INS_END,   32'h7fffffff, 5'd0);
    send_request(OP_REVERSE,   32'd0,        5'd0);
    send_request(OP_INS_FRONT, 32'h80000000, 5'd31);
    send_request(OP_INS_AT,    32'd1,        5'd0);
    send_request(OP_INS_AT,    32'hffffffff, 5'd2);
    send_request(OP_INS_AT,    32'd2,        5'd4);
    send_request(OP_INS_AT,    32'd3,        5'd31);
    send_request(OP_INS_AT,    32'h12345678, 5'd1);
    send_request(OP_DUMP,      32'd0,        5'd0);
    send_request(OP_REVERSE,   32'd0,        5'd0);
    send_request(OP_DUMP,      32'd0,        5'd0);
    send_request(OP_DEL_VALUE, 32'h55aa55aa, 5'd0);
    send_request(OP_DEL_VALUE, 32'hffffffff, 5'd0);
    send_request(OP_DEL_AT,    32'd0,        5'd0);
    send_request(OP_DEL_AT,    32'd0,        5'd3);
    send_request(OP_LAST_UNUSED,  32'hdeadbeef, 5'd31);
    send_request(OP_FIRST_UNUSED, 32'd0,        5'd0);
    send_request(OP_DUMP,      32'd0,        5'd0);

    foreach (limits[i]) begin
      write_limit(limits[i]);
      // With the limit above capacity, try to fill the list past capacity first.
      if (limits[i] > LIST_CAP) begin
        for (int k = 0; k < LIST_CAP + 1; k++) send_request(OP_INS_END, $urandom(), 5'd0);
        send_request(OP_DUMP, 32'd0, 5'd0);
      end
      run_random(RANDOM_PER_SET);
    end

    drain_results();
    if (board.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
